/* sv/rrip_replacement_with_stream_bypass_top_defines.svh */
// Assertion macros shared by the replacement policy checker.
// Depends on clk and arst_n being visible where the macros are used.
`ifndef RRIP_REPLACEMENT_WITH_STREAM_BYPASS_TOP_DEFINES_SVH
`define RRIP_REPLACEMENT_WITH_STREAM_BYPASS_TOP_DEFINES_SVH

// Checked only while out of reset.
`define RSB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define RSB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/rripsb_pkg.sv */
// Types and constants of the RRIP replacement policy with stream bypass.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none
package rripsb_pkg;

	typedef struct packed {
		logic        command;
		logic [10:0] set_index;
		logic [3:0]  way_index;
		logic        was_hit;
		logic [12:0] pc_bits;
		logic [63:0] phys_addr;
	} item_t;

	typedef struct packed {
		logic [3:0] victim_way;
		logic       stream_flag;
	} result_t;

	localparam logic CMD_QUERY  = 1'b0;
	localparam logic CMD_UPDATE = 1'b1;

	localparam logic [2:0] CFG_STREAM_THRESHOLD = 3'd0;
	localparam logic [2:0] CFG_DECAY_LOG2       = 3'd1;
	localparam logic [2:0] CFG_BIMODAL_LOG2     = 3'd2;
	localparam logic [2:0] CFG_REUSE_HIGH       = 3'd3;
	localparam logic [2:0] CFG_REUSE_LOW        = 3'd4;

	localparam logic [1:0] SIGN_ZERO = 2'd0;
	localparam logic [1:0] SIGN_POS  = 2'd1;
	localparam logic [1:0] SIGN_NEG  = 2'd2;

	localparam logic [1:0] AGE_MAX     = 2'd3;
	localparam logic [1:0] AGE_LONG    = 2'd2;
	localparam logic [1:0] AGE_NEAR    = 2'd0;
	localparam logic [5:0] REUSE_MAX   = 6'd63;
	localparam logic [5:0] REUSE_RESET = 6'd3;
	localparam logic [9:0] SEL_MAX     = 10'd1023;
	localparam logic [9:0] SEL_MID     = 10'd512;

endpackage
`default_nettype wire

/* sv/rrip_replacement_with_stream_bypass_top.sv */
// Top level of the RRIP replacement policy with stream bypass.
// Depends on rripsb_pkg and rripsb_ram.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------
//  command  | start, busy                | item (rripsb_pkg::item_t)
//  config   | cfg_valid, cfg_ready       | cfg_index, cfg_data
//  result   | done (one-cycle strobe)    | result (rripsb_pkg::result_t)
//
// A victim query passes the read and victim states, an update the read, stream and update
// states; each raises done in its last state, and the next transaction is taken the cycle
// after done. An update that lands on a decay point also passes a decay state that sweeps
// the reuse memory through the single read port of that memory.
// After reset a clearing pass over every memory entry keeps busy high.
// Results are shown for one cycle only and cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module rrip_replacement_with_stream_bypass_top #(
	parameter int SETS          = 2048,
	parameter int WAYS          = 16,
	parameter int SIG_ENTRIES   = 2048,
	parameter int HISTORY_DEPTH = 4,
	parameter int DUEL_PERIOD   = 64,
	parameter int LEADER_COUNT  = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  rripsb_pkg::item_t   item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [5:0]          cfg_data,
	output logic                done,
	output rripsb_pkg::result_t result
);

	import rripsb_pkg::*;

	localparam int SW     = $clog2(SETS);
	localparam int WW     = $clog2(WAYS);
	localparam int GW     = $clog2(SIG_ENTRIES);
	localparam int HW     = $clog2(HISTORY_DEPTH);
	localparam int AGE_W  = 2 * WAYS;
	localparam int HIST_W = 64 + 2 * HISTORY_DEPTH + HW;
	localparam int CLR_N  = (SETS > SIG_ENTRIES) ? SETS : SIG_ENTRIES;
	localparam int CW     = $clog2(CLR_N) + 1;

	localparam longint unsigned MOD_ONE = 64'd1 << 22;
	localparam longint unsigned R_SET   = (MOD_ONE + SETS - 1) / SETS;
	localparam longint unsigned R_SIG   = (MOD_ONE + SIG_ENTRIES - 1) / SIG_ENTRIES;
	localparam bit SET_DIRECT = (SETS >= 2048);
	localparam bit SIG_DIRECT = (SIG_ENTRIES >= 2048);
	localparam int PK  = SW + 10;
	localparam int PRW = SW + PK + 1;
	localparam longint unsigned R_ROLE = ((64'd1 << PK) + DUEL_PERIOD - 1) / DUEL_PERIOD;

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_DEC  = 3'd3;
	localparam logic [2:0] ST_STR  = 3'd4;
	localparam logic [2:0] ST_UPD  = 3'd5;
	localparam logic [2:0] ST_VIC  = 3'd6;

	typedef struct packed {
		logic [HW-1:0]                  slot;
		logic [HISTORY_DEPTH-1:0][1:0]  sign;
		logic [63:0]                    last;
	} hist_t;

	logic [2:0]    state_q;
	logic [CW-1:0] clr_q;
	logic [GW:0]   dec_q;
	item_t         item_q;
	logic [10:0]   qset_q;
	logic [10:0]   qsig_q;
	logic [SW-1:0] set_q;
	logic [WW-1:0] way_q;
	logic [GW-1:0] sig_q;
	logic [SW-1:0] qrole_q;
	logic          stream_q;
	logic [11:0]   cnt_q;
	logic [9:0]    sel_q;
	logic [2:0]    thr_q;
	logic [3:0]    dec_log_q;
	logic [3:0]    bim_log_q;
	logic [5:0]    hi_q;
	logic [5:0]    lo_q;

	logic                    age_we, age_re, hist_we, hist_re, reuse_we, reuse_re;
	logic [SW-1:0]           age_waddr, hist_waddr;
	logic [GW-1:0]           reuse_waddr, reuse_raddr;
	logic [WAYS-1:0][1:0]    age_rdata, age_wdata, aged;
	hist_t                   hist_rdata, hist_wdata, hist_new;
	logic [5:0]              reuse_rdata, reuse_wdata;

	logic [10:0]   sig_raw, sig_in_raw;
	logic [31:0]   set_rem, sig_rem, role_rem;
	logic [SW-1:0] set_c;
	logic [GW-1:0] sig_c;
	logic [4:0]    way_tmp;
	logic [WW-1:0] way_c;
	logic [3:0]    dec_len, bim_len;
	logic          dec_need, bim_zero;
	logic [3:0]    pos_n, neg_n, thr_w;
	logic          stream_c;
	logic [63:0]   delta;
	logic [1:0]    code;
	logic          srrip_lead, brrip_lead;
	logic [1:0]    ins_age, upd_age;
	logic          found1, found2;
	logic [WW-1:0] idx1, idx2, victim;

	function automatic logic low_zero(input logic [11:0] cnt, input logic [3:0] len);
		logic z;
		z = 1'b1;
		for (int i = 0; i < 12; i++) begin
			if ((4'(i) < len) && cnt[i]) begin
				z = 1'b0;
			end
		end
		return z;
	endfunction

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	assign sig_in_raw = item.pc_bits[10:0] ^ item.pc_bits[12:2];
	assign sig_raw    = item_q.pc_bits[10:0] ^ item_q.pc_bits[12:2];

	always_comb begin
		set_rem = 32'(item_q.set_index) - 32'(qset_q) * 32'(SETS);
		if (set_rem >= 32'(SETS)) begin
			set_rem = set_rem - 32'(SETS);
		end
		if (SET_DIRECT) begin
			set_rem = 32'(item_q.set_index);
		end
		set_c = SW'(set_rem);

		sig_rem = 32'(sig_raw) - 32'(qsig_q) * 32'(SIG_ENTRIES);
		if (sig_rem >= 32'(SIG_ENTRIES)) begin
			sig_rem = sig_rem - 32'(SIG_ENTRIES);
		end
		if (SIG_DIRECT) begin
			sig_rem = 32'(sig_raw);
		end
		sig_c = GW'(sig_rem);

		way_tmp = 5'(item_q.way_index);
		for (int i = 0; i < 8; i++) begin
			if (32'(way_tmp) >= 32'(WAYS)) begin
				way_tmp = 5'(32'(way_tmp) - 32'(WAYS));
			end
		end
		way_c = WW'(way_tmp);
	end

	always_comb begin
		dec_len  = (dec_log_q == 4'd0) ? 4'd1 : ((dec_log_q > 4'd12) ? 4'd12 : dec_log_q);
		bim_len  = (bim_log_q == 4'd0) ? 4'd1 : ((bim_log_q > 4'd10) ? 4'd10 : bim_log_q);
		dec_need = low_zero(cnt_q, dec_len);
		bim_zero = low_zero(cnt_q, bim_len);
	end

	always_comb begin
		hist_new = hist_rdata;
		delta    = item_q.phys_addr - hist_rdata.last;
		code     = (delta == 64'd0) ? SIGN_ZERO : (delta[63] ? SIGN_NEG : SIGN_POS);
		if (hist_rdata.last != 64'd0) begin
			hist_new.sign[hist_rdata.slot] = code;
			if (32'(hist_rdata.slot) == HISTORY_DEPTH - 1) begin
				hist_new.slot = '0;
			end else begin
				hist_new.slot = hist_rdata.slot + 1'b1;
			end
		end
		hist_new.last = item_q.phys_addr;
		pos_n = '0;
		neg_n = '0;
		for (int i = 0; i < HISTORY_DEPTH; i++) begin
			if (hist_new.sign[i] == SIGN_POS) begin
				pos_n = pos_n + 4'd1;
			end
			if (hist_new.sign[i] == SIGN_NEG) begin
				neg_n = neg_n + 4'd1;
			end
		end
		thr_w    = 4'(thr_q);
		stream_c = ((pos_n + neg_n) >= thr_w) && ((pos_n >= thr_w) || (neg_n >= thr_w));
	end

	always_comb begin
		role_rem = 32'(set_q) - 32'(qrole_q) * 32'(DUEL_PERIOD);
		if (role_rem >= 32'(DUEL_PERIOD)) begin
			role_rem = role_rem - 32'(DUEL_PERIOD);
		end
		srrip_lead = (role_rem < 32'(LEADER_COUNT));
		brrip_lead = !srrip_lead && (role_rem >= 32'(DUEL_PERIOD - LEADER_COUNT));
		if (srrip_lead || (!brrip_lead && (sel_q >= SEL_MID))) begin
			ins_age = AGE_LONG;
		end else begin
			ins_age = bim_zero ? AGE_LONG : AGE_MAX;
		end
		if (item_q.was_hit) begin
			upd_age = AGE_NEAR;
		end else if (stream_q) begin
			upd_age = AGE_MAX;
		end else if (reuse_rdata >= hi_q) begin
			upd_age = AGE_NEAR;
		end else if (reuse_rdata <= lo_q) begin
			upd_age = AGE_MAX;
		end else begin
			upd_age = ins_age;
		end
	end

	always_comb begin
		found1 = 1'b0;
		found2 = 1'b0;
		idx1   = '0;
		idx2   = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			aged[i] = (age_rdata[i] == AGE_MAX) ? AGE_MAX : age_rdata[i] + 2'd1;
			if (age_rdata[i] == AGE_MAX) begin
				found1 = 1'b1;
				idx1   = WW'(i);
			end
			if (age_rdata[i] == AGE_LONG) begin
				found2 = 1'b1;
				idx2   = WW'(i);
			end
		end
		victim = found1 ? idx1 : (found2 ? idx2 : '0);
	end

	always_comb begin
		age_we      = 1'b0;
		age_waddr   = set_q;
		age_wdata   = age_rdata;
		age_re      = 1'b0;
		hist_we     = 1'b0;
		hist_waddr  = set_q;
		hist_wdata  = hist_new;
		hist_re     = 1'b0;
		reuse_we    = 1'b0;
		reuse_waddr = sig_q;
		reuse_wdata = reuse_rdata + 6'd1;
		reuse_re    = 1'b0;
		reuse_raddr = sig_q;
		done        = 1'b0;
		result      = '0;
		case (state_q)
			ST_CLR: begin
				age_we      = (32'(clr_q) < SETS);
				age_waddr   = SW'(clr_q);
				age_wdata   = '1;
				hist_we     = age_we;
				hist_waddr  = SW'(clr_q);
				hist_wdata  = '0;
				reuse_we    = (32'(clr_q) < SIG_ENTRIES);
				reuse_waddr = GW'(clr_q);
				reuse_wdata = REUSE_RESET;
			end
			ST_RD: begin
				age_re = 1'b1;
				hist_re = 1'b1;
			end
			ST_DEC: begin
				reuse_re    = (32'(dec_q) < SIG_ENTRIES);
				reuse_raddr = GW'(dec_q);
				reuse_we    = (dec_q != '0);
				reuse_waddr = GW'(dec_q - 1'b1);
				reuse_wdata = reuse_rdata >> 1;
			end
			ST_STR: begin
				hist_we  = 1'b1;
				reuse_re = 1'b1;
			end
			ST_UPD: begin
				age_we             = 1'b1;
				age_wdata[way_q]   = upd_age;
				reuse_we           = item_q.was_hit && (reuse_rdata != REUSE_MAX);
				done               = 1'b1;
				result.stream_flag = stream_q;
			end
			ST_VIC: begin
				age_we            = !found1;
				age_wdata         = aged;
				done              = 1'b1;
				result.victim_way = 4'(victim);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			dec_q   <= '0;
			cnt_q   <= '0;
			sel_q   <= SEL_MID;
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == CLR_N - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RD;
						if (item.command == CMD_UPDATE) begin
							cnt_q <= cnt_q + 12'd1;
						end
					end
				end
				ST_RD: begin
					dec_q <= '0;
					if (item_q.command == CMD_QUERY) begin
						state_q <= ST_VIC;
					end else if (dec_need) begin
						state_q <= ST_DEC;
					end else begin
						state_q <= ST_STR;
					end
				end
				ST_DEC: begin
					dec_q <= dec_q + 1'b1;
					if (32'(dec_q) == SIG_ENTRIES) begin
						state_q <= ST_STR;
					end
				end
				ST_STR: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					state_q <= ST_IDLE;
					if (item_q.was_hit && srrip_lead && (sel_q != SEL_MAX)) begin
						sel_q <= sel_q + 10'd1;
					end else if (item_q.was_hit && brrip_lead && (sel_q != '0)) begin
						sel_q <= sel_q - 10'd1;
					end
				end
				ST_VIC: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			item_q <= item;
			qset_q <= 11'((34'(item.set_index) * 34'(R_SET)) >> 22);
			qsig_q <= 11'((34'(sig_in_raw) * 34'(R_SIG)) >> 22);
		end
		if (state_q == ST_RD) begin
			set_q <= set_c;
			way_q <= way_c;
			sig_q <= sig_c;
		end
		if (state_q == ST_STR) begin
			stream_q <= stream_c;
			qrole_q  <= SW'((PRW'(set_q) * PRW'(R_ROLE)) >> PK);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= 3'd3;
			dec_log_q <= 4'd12;
			bim_log_q <= 4'd5;
			hi_q      <= 6'd62;
			lo_q      <= 6'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_STREAM_THRESHOLD: thr_q     <= cfg_data[2:0];
				CFG_DECAY_LOG2:       dec_log_q <= cfg_data[3:0];
				CFG_BIMODAL_LOG2:     bim_log_q <= cfg_data[3:0];
				CFG_REUSE_HIGH:       hi_q      <= cfg_data;
				CFG_REUSE_LOW:        lo_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	rripsb_ram #(.WIDTH(AGE_W), .DEPTH(SETS)) u_age_ram (
		.clk   (clk),
		.we    (age_we),
		.waddr (age_waddr),
		.wdata (age_wdata),
		.re    (age_re),
		.raddr (set_c),
		.rdata (age_rdata)
	);

	rripsb_ram #(.WIDTH(HIST_W), .DEPTH(SETS)) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.re    (hist_re),
		.raddr (set_c),
		.rdata (hist_rdata)
	);

	rripsb_ram #(.WIDTH(6), .DEPTH(SIG_ENTRIES)) u_reuse_ram (
		.clk   (clk),
		.we    (reuse_we),
		.waddr (reuse_waddr),
		.wdata (reuse_wdata),
		.re    (reuse_re),
		.raddr (reuse_raddr),
		.rdata (reuse_rdata)
	);

endmodule
`default_nettype wire

/* sv/rripsb_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rripsb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* sv/rripsb_checker.sv */
// Port-level checker for the replacement policy top level, with its bind.
// Depends on rripsb_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "rrip_replacement_with_stream_bypass_top_defines.svh"
module rripsb_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  rripsb_pkg::item_t   item,
	input  logic                done,
	input  rripsb_pkg::result_t result
);

	import rripsb_pkg::*;

	logic cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= CMD_QUERY;
		end else if (start && !busy) begin
			cmd_q <= item.command;
		end
	end

	`RSB_ASSERT(a_done_ends_busy, done |=> !busy, "busy still high after the result")
	`RSB_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted transaction did not raise busy")
	`RSB_ASSERT(a_query_no_stream, (done && (cmd_q == CMD_QUERY)) |-> !result.stream_flag, "query reported streaming")
	`RSB_ASSERT(a_update_way_zero, (done && (cmd_q == CMD_UPDATE)) |-> (result.victim_way == 4'd0), "update reported a way")
	`RSB_ASSERT_ALWAYS(a_no_done_in_reset, !arst_n |-> !done, "result strobe during reset")

endmodule

bind rrip_replacement_with_stream_bypass_top rripsb_checker u_rripsb_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.item   (item),
	.done   (done),
	.result (result)
);
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the RRIP replacement policy with stream bypass.
// Depends on rripsb_pkg and rrip_replacement_with_stream_bypass_top; a local policy
// predictor checks every result transaction against its own copy of the state.
`timescale 1ns / 1ps
module tb;
	import rripsb_pkg::*;

	typedef enum logic [1:0] {JOB_ITEM, JOB_CFG, JOB_DRAIN} job_kind_t;

	typedef struct {
		job_kind_t  kind;
		item_t      cmd;
		logic [2:0] idx;
		logic [5:0] data;
		int         gap;
	} job_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	item_t      item = '0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [5:0] cfg_data = '0;
	logic       done;
	result_t    result;

	rrip_replacement_with_stream_bypass_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .result(result)
	);

	job_t    jobs[$];
	result_t expected_results[$];
	int      mismatches = 0;

	// Predictor state.
	logic [1:0]  way_age[0:32767];
	logic [5:0]  reuse_cnt[0:2047];
	logic [9:0]  duel_sel;
	logic [11:0] access_cnt;
	logic [63:0] prev_addr[0:2047];
	logic [1:0]  delta_code[0:8191];
	logic [1:0]  hist_ptr[0:2047];
	logic [2:0]  thresh_r;
	logic [3:0]  decay_r;
	logic [3:0]  bimodal_r;
	logic [5:0]  high_r;
	logic [5:0]  low_r;

	// Stimulus helpers.
	logic [63:0] next_addr[0:2047];
	int          zero_gap_run = 0;

	function automatic void policy_reset();
		for (int i = 0; i < 32768; i++) way_age[i] = AGE_MAX;
		for (int i = 0; i < 2048; i++) begin
			reuse_cnt[i] = REUSE_RESET;
			prev_addr[i] = '0;
			hist_ptr[i] = '0;
			next_addr[i] = 64'h1000 * (i + 1);
		end
		for (int i = 0; i < 8192; i++) delta_code[i] = SIGN_ZERO;
		duel_sel = SEL_MID;
		access_cnt = '0;
		thresh_r = 3'd3;
		decay_r = 4'd12;
		bimodal_r = 4'd5;
		high_r = 6'd62;
		low_r = 6'd1;
	endfunction

	function automatic void policy_config(logic [2:0] idx, logic [5:0] data);
		case (idx)
			CFG_STREAM_THRESHOLD: thresh_r = data[2:0];
			CFG_DECAY_LOG2:       decay_r = data[3:0];
			CFG_BIMODAL_LOG2:     bimodal_r = data[3:0];
			CFG_REUSE_HIGH:       high_r = data;
			CFG_REUSE_LOW:        low_r = data;
			default: begin
			end
		endcase
	endfunction

	function automatic result_t policy_step(item_t it);
		result_t     r;
		int          set_n;
		int          slot_idx;
		int          npos;
		int          nneg;
		int          dlog;
		int          blog;
		int          duel_pos;
		logic [63:0] delta;
		logic [1:0]  code;
		logic [1:0]  ins;
		logic [10:0] sig;
		logic [12:0] pc;
		logic        streaming;
		logic        found;
		r = '0;
		set_n = int'(it.set_index);
		if (it.command == CMD_QUERY) begin
			found = 1'b0;
			for (int w = 0; w < 16; w++)
				if (!found && way_age[set_n * 16 + w] == AGE_MAX) begin
					r.victim_way = 4'(w);
					found = 1'b1;
				end
			if (!found) begin
				for (int w = 0; w < 16; w++)
					if (way_age[set_n * 16 + w] < AGE_MAX)
						way_age[set_n * 16 + w]++;
				for (int w = 0; w < 16; w++)
					if (!found && way_age[set_n * 16 + w] == AGE_MAX) begin
						r.victim_way = 4'(w);
						found = 1'b1;
					end
			end
			return r;
		end
		slot_idx = set_n * 16 + it.way_index;
		pc = it.pc_bits;
		access_cnt++;
		if (prev_addr[set_n] != 0) begin
			delta = it.phys_addr - prev_addr[set_n];
			code = (delta == 0) ? SIGN_ZERO : (delta[63] ? SIGN_NEG : SIGN_POS);
			delta_code[set_n * 4 + hist_ptr[set_n]] = code;
			hist_ptr[set_n]++;
		end
		prev_addr[set_n] = it.phys_addr;
		npos = 0;
		nneg = 0;
		for (int i = 0; i < 4; i++) begin
			if (delta_code[set_n * 4 + i] == SIGN_POS) npos++;
			else if (delta_code[set_n * 4 + i] == SIGN_NEG) nneg++;
		end
		streaming = (npos + nneg >= thresh_r) && (npos >= thresh_r || nneg >= thresh_r);
		dlog = (decay_r < 1) ? 1 : ((decay_r > 12) ? 12 : decay_r);
		if ((access_cnt & ((12'd1 << dlog) - 12'd1)) == 0)
			for (int i = 0; i < 2048; i++) reuse_cnt[i] = reuse_cnt[i] >> 1;
		r.stream_flag = streaming;
		if (!it.was_hit && streaming) begin
			way_age[slot_idx] = AGE_MAX;
			return r;
		end
		sig = pc[10:0] ^ pc[12:2];
		duel_pos = set_n % 64;
		if (it.was_hit) begin
			way_age[slot_idx] = AGE_NEAR;
			if (reuse_cnt[sig] < REUSE_MAX) reuse_cnt[sig]++;
			if (duel_pos < 32) begin
				if (duel_sel < SEL_MAX) duel_sel++;
			end else if (duel_pos >= 64 - 32) begin
				if (duel_sel > 0) duel_sel--;
			end
			return r;
		end
		blog = (bimodal_r < 1) ? 1 : ((bimodal_r > 10) ? 10 : bimodal_r);
		if (duel_pos < 32 || (duel_pos < 64 - 32 && duel_sel >= SEL_MID))
			ins = AGE_LONG;
		else
			ins = ((access_cnt & ((12'd1 << blog) - 12'd1)) == 0) ? AGE_LONG : AGE_MAX;
		if (reuse_cnt[sig] >= high_r) way_age[slot_idx] = AGE_NEAR;
		else if (reuse_cnt[sig] <= low_r) way_age[slot_idx] = AGE_MAX;
		else way_age[slot_idx] = ins;
		return r;
	endfunction

	function automatic int draw_gap();
		if (zero_gap_run > 0) begin
			zero_gap_run--;
			return 0;
		end
		if ($urandom_range(0, 29) == 0) zero_gap_run = $urandom_range(10, 40);
		return $urandom_range(0, 11);
	endfunction

	function automatic void add_item(logic cmd, int set_n, int way, logic hit, int pc,
			logic [63:0] addr);
		job_t j;
		j.kind = JOB_ITEM;
		j.cmd.command = cmd;
		j.cmd.set_index = 11'(set_n);
		j.cmd.way_index = 4'(way);
		j.cmd.was_hit = hit;
		j.cmd.pc_bits = 13'(pc);
		j.cmd.phys_addr = addr;
		j.idx = '0;
		j.data = '0;
		j.gap = draw_gap();
		jobs.push_back(j);
	endfunction

	function automatic void add_cfg(logic [2:0] idx, int data);
		job_t j;
		j.kind = JOB_CFG;
		j.cmd = '0;
		j.idx = idx;
		j.data = 6'(data);
		j.gap = 0;
		jobs.push_back(j);
	endfunction

	function automatic void add_drain();
		job_t j;
		j.kind = JOB_DRAIN;
		j.cmd = '0;
		j.idx = '0;
		j.data = '0;
		j.gap = 0;
		jobs.push_back(j);
	endfunction

	function automatic void add_settings(int th, int dc, int bm, int hi, int lo);
		add_cfg(CFG_STREAM_THRESHOLD, th);
		add_cfg(CFG_DECAY_LOG2, dc);
		add_cfg(CFG_BIMODAL_LOG2, bm);
		add_cfg(CFG_REUSE_HIGH, hi);
		add_cfg(CFG_REUSE_LOW, lo);
	endfunction

	// Traffic is mostly a few hot sets and program counters with strided addresses, so that
	// streaming, reuse saturation and aging all get exercised.
	function automatic void add_random(int n);
		int          hot_sets[10] = '{0, 5, 31, 32, 33, 63, 64, 100, 1000, 2047};
		int          hot_pcs[6] = '{0, 4, 100, 8191, 4660, 2047};
		int          set_n;
		int          pc;
		int          mode;
		logic [63:0] addr;
		logic        cmd;
		for (int k = 0; k < n; k++) begin
			cmd = ($urandom_range(0, 9) < 4) ? CMD_QUERY : CMD_UPDATE;
			set_n = ($urandom_range(0, 9) < 7) ? hot_sets[$urandom_range(0, 9)]
				: $urandom_range(0, 2047);
			pc = ($urandom_range(0, 9) < 6) ? hot_pcs[$urandom_range(0, 5)]
				: $urandom_range(0, 8191);
			mode = $urandom_range(0, 9);
			if (mode < 5) addr = next_addr[set_n] + 64 * $urandom_range(1, 8);
			else if (mode < 7) addr = next_addr[set_n] - 64 * $urandom_range(1, 8);
			else if (mode < 8) addr = next_addr[set_n];
			else if (mode < 9) addr = '0;
			else addr = {$urandom, $urandom};
			if (cmd == CMD_UPDATE) next_addr[set_n] = addr;
			add_item(cmd, set_n, int'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), pc,
				addr);
		end
	endfunction

	initial begin
		forever #5 clk = ~clk;
	end

	// Driver: launches one job at a time from the pending queue.
	int idle_cnt = 0;
	int quiet_cnt = 0;
	always @(posedge clk or negedge arst_n) begin
		logic s_n;
		logic c_n;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_valid <= 1'b0;
			item <= '0;
			cfg_index <= '0;
			cfg_data <= '0;
		end else begin
			s_n = start;
			c_n = cfg_valid;
			if (start && !busy) begin
				expected_results.push_back(policy_step(item));
				void'(jobs.pop_front());
				s_n = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				policy_config(cfg_index, cfg_data);
				void'(jobs.pop_front());
				c_n = 1'b0;
			end
			quiet_cnt = (expected_results.size() == 0 && !s_n) ? quiet_cnt + 1 : 0;
			if (!s_n && !c_n && jobs.size() > 0) begin
				case (jobs[0].kind)
					JOB_ITEM: begin
						if (idle_cnt >= jobs[0].gap) begin
							item <= jobs[0].cmd;
							s_n = 1'b1;
							idle_cnt = 0;
						end else begin
							idle_cnt++;
						end
					end
					JOB_CFG: begin
						if (quiet_cnt >= 8) begin
							cfg_index <= jobs[0].idx;
							cfg_data <= jobs[0].data;
							c_n = 1'b1;
						end
					end
					default: begin
						if (quiet_cnt >= 1) void'(jobs.pop_front());
					end
				endcase
			end
			start <= s_n;
			cfg_valid <= c_n;
		end
	end

	// Monitor: every result transaction is checked against the oldest expectation.
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: way %0d stream %0b",
						result.victim_way, result.stream_flag);
			end else begin
				exp_r = expected_results.pop_front();
				if (result.victim_way !== exp_r.victim_way
						|| result.stream_flag !== exp_r.stream_flag) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected way %0d stream %0b, got way %0d stream %0b",
							exp_r.victim_way, exp_r.stream_flag,
							result.victim_way, result.stream_flag);
				end
			end
		end
	end

	// Watchdog: ends the run when nothing moves for too long.
	int stuck_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || (cfg_valid && cfg_ready) || done) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= 30000) begin
			$display("FAIL");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin
		policy_reset();
		// Directed part at reset settings.
		add_item(CMD_QUERY, 0, 0, 1'b0, 0, 64'd0);
		add_item(CMD_UPDATE, 2047, 15, 1'b1, 8191, '1);
		add_item(CMD_UPDATE, 2047, 15, 1'b0, 8191, 64'd0);
		add_item(CMD_UPDATE, 2047, 0, 1'b0, 0, 64'h8000_0000_0000_0000);
		add_item(CMD_UPDATE, 3, 1, 1'b0, 12, 64'd100);
		add_item(CMD_UPDATE, 3, 2, 1'b0, 12, 64'd200);
		add_item(CMD_UPDATE, 3, 3, 1'b0, 12, 64'd300);
		add_item(CMD_UPDATE, 3, 4, 1'b0, 12, 64'd400);
		add_item(CMD_UPDATE, 3, 5, 1'b1, 12, 64'd500);
		add_item(CMD_QUERY, 3, 0, 1'b0, 0, 64'd0);
		add_item(CMD_UPDATE, 40, 0, 1'b1, 33, 64'd64);
		add_item(CMD_UPDATE, 40, 1, 1'b0, 33, 64'd64);
		add_item(CMD_UPDATE, 40, 2, 1'b0, 33, 64'd0);
		add_item(CMD_UPDATE, 7, 0, 1'b1, 5, 64'd900);
		add_item(CMD_QUERY, 7, 0, 1'b0, 0, 64'd0);
		add_item(CMD_QUERY, 2047, 0, 1'b0, 0, 64'd0);
		add_random(150);
		add_settings(1, 12, 1, 63, 0);
		add_cfg(3'd5, 6'h3F);
		add_cfg(3'd7, 6'h15);
		add_random(200);
		add_settings(4, 3, 10, 0, 63);
		add_random(60);
		add_settings(0, 0, 0, 40, 5);
		add_random(20);
		add_settings(7, 15, 15, 20, 10);
		add_random(150);
		add_settings(2, 12, 4, 62, 1);
		add_random(120);
		add_drain();
		add_random(120);
		add_settings(3, 10, 5, 8, 2);
		add_random(120);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (jobs.size() != 0 || expected_results.size() != 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

/* files.f */
+incdir+sv
sv/rripsb_pkg.sv
sv/rripsb_ram.sv
sv/rrip_replacement_with_stream_bypass_top.sv
sv/rripsb_checker.sv
tb/tb.sv
